@@ rtl/bscd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscd_pkg: shared definitions for the button scan change detector
// Scan geometry, register map, reset values and inter-module types.
// ----------------------------------------------------------------------------
package bscd_pkg;

	// scan geometry
	localparam int SCAN_BYTES = 9;
	localparam int ADDR_W     = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
	localparam int INDEX_W    = 4;
	localparam int BYTE_W     = 8;
	localparam int BIT_W      = 3;
	localparam int BUTTON_W   = INDEX_W + BIT_W;

	// configuration port
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MASKED_BYTE_INDEX = 2'd0,
		CFG_MASKED_BYTE_KEEP  = 2'd1
	} cfg_reg_t;

	localparam logic [INDEX_W-1:0] MASKED_INDEX_RESET = 4'd5;
	localparam logic [BYTE_W-1:0]  MASKED_KEEP_RESET  = 8'hE1;

	// load word from the compare stage into the event emitter
	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] changes;
		logic [BYTE_W-1:0] states;
		logic [INDEX_W-1:0] index;
	} emit_load_t;

endpackage

@@ rtl/bscd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscd_ram: generic single-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/bscd_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscd_emit: change event emitter
// Holds the pending change bits of one byte and presents one event per word,
// lowest changed bit first, marking the final event of the byte.
// ----------------------------------------------------------------------------
module bscd_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bscd_pkg::emit_load_t           load,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [bscd_pkg::BUTTON_W-1:0]  button_number,
	output logic                           pressed,
	output logic                           last_event
);

	logic [bscd_pkg::BYTE_W-1:0]  pend_q;
	logic [bscd_pkg::BYTE_W-1:0]  states_q;
	logic [bscd_pkg::INDEX_W-1:0] index_q;
	logic [bscd_pkg::BYTE_W-1:0]  low_onehot;
	logic [bscd_pkg::BYTE_W-1:0]  rest;
	logic [bscd_pkg::BIT_W-1:0]   low_bit;

	// isolate the lowest pending bit and what remains after it
	assign low_onehot = pend_q & (~pend_q + bscd_pkg::BYTE_W'(1));
	assign rest       = pend_q & (pend_q - bscd_pkg::BYTE_W'(1));

	// encode the one-hot position
	always_comb begin
		low_bit = '0;
		for (int i = 0; i < bscd_pkg::BYTE_W; i++) begin
			if (low_onehot[i]) begin
				low_bit = low_bit | bscd_pkg::BIT_W'(i);
			end
		end
	end

	assign out_valid     = |pend_q;
	assign button_number = {index_q, low_bit};
	assign pressed       = |(states_q & low_onehot);
	assign last_event    = (rest == '0);

	// pending change bits: load a new byte, drop each bit as its word leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load.load) begin
			pend_q <= load.changes;
		end else if (out_valid && out_ready) begin
			pend_q <= rest;
		end
	end

	// payload of the byte being reported
	always_ff @(posedge clk) begin
		if (load.load) begin
			states_q <= load.states;
			index_q  <= load.index;
		end
	end

endmodule

@@ rtl/button_scan_change_events.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_scan_change_events: button scan change detector
// Compares each scanned byte with the byte of the previous scan and emits
// one press or release event per changed button.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: byte_index and scan_byte.
//   Output channel (out_valid/out_ready) gives one word per changed bit,
//   lowest bit first: button_number, pressed, and last_event on the final
//   word of the byte. An unchanged byte or an index of SCAN_BYTES or more
//   gives no words; an out-of-range index leaves the stored scan untouched.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   masked_byte_index (index 0) and masked_byte_keep (index 1); other
//   indexes are ignored. Write it only while the block is idle.
//   Flow: a byte is read from the scan RAM in the cycle it is accepted,
//   compared and written back the next cycle, and its first event appears
//   in the cycle after that. Each changed bit gives one event. An unchanged
//   byte returns the block to idle first, and an out-of-range index is taken
//   without a RAM access. The output gives one event per cycle while the
//   receiver is ready; each in-range byte makes one RAM read-modify-write.
//   The next byte is taken in the cycle the final event leaves.
//   A stalled receiver holds the current event and blocks further input.
//   Reset clears the per-entry valid bits, so every stored byte reads as
//   all released; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_scan_change_events (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bscd_pkg::INDEX_W-1:0]      byte_index,
	input  logic [bscd_pkg::BYTE_W-1:0]       scan_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bscd_pkg::BUTTON_W-1:0]     button_number,
	output logic                              pressed,
	output logic                              last_event,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bscd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bscd_pkg::BYTE_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [bscd_pkg::INDEX_W-1:0]  masked_index_q;
	logic [bscd_pkg::BYTE_W-1:0]   masked_keep_q;
	logic [bscd_pkg::SCAN_BYTES-1:0] valid_q;
	logic [bscd_pkg::INDEX_W-1:0]  index_s1;
	logic [bscd_pkg::BYTE_W-1:0]   cur_s1;
	logic [bscd_pkg::BYTE_W-1:0]   ram_rdata;
	logic [bscd_pkg::BYTE_W-1:0]   prev;
	logic [bscd_pkg::BYTE_W-1:0]   keep;
	logic [bscd_pkg::BYTE_W-1:0]   cur_masked;
	logic [bscd_pkg::BYTE_W-1:0]   prev_masked;
	logic [bscd_pkg::BYTE_W-1:0]   changes;
	logic [bscd_pkg::ADDR_W-1:0]   addr_s1;
	logic                          in_accept;
	logic                          in_range;
	logic                          last_taken;
	logic                          lookup;
	bscd_pkg::emit_load_t          emit_load;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masked_index_q <= bscd_pkg::MASKED_INDEX_RESET;
			masked_keep_q  <= bscd_pkg::MASKED_KEEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bscd_pkg::CFG_MASKED_BYTE_INDEX: masked_index_q <= cfg_data[bscd_pkg::INDEX_W-1:0];
				bscd_pkg::CFG_MASKED_BYTE_KEEP:  masked_keep_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input handshake: take a byte when idle or as the final event leaves
	assign last_taken = out_valid && out_ready && last_event;
	assign in_ready   = (state_q == ST_IDLE) || ((state_q == ST_EMIT) && last_taken);
	assign in_accept  = in_valid && in_ready;
	assign in_range   = (byte_index < bscd_pkg::INDEX_W'(bscd_pkg::SCAN_BYTES));
	assign lookup     = (state_q == ST_LOOKUP);

	// next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && in_range) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = (changes != '0) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (in_accept && in_range) begin
					state_d = ST_LOOKUP;
				end else if (last_taken) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the accepted byte for the compare stage
	always_ff @(posedge clk) begin
		if (in_accept) begin
			index_s1 <= byte_index;
			cur_s1   <= scan_byte;
		end
	end

	assign addr_s1 = index_s1[bscd_pkg::ADDR_W-1:0];

	// previous scan storage
	bscd_ram #(
		.WIDTH (bscd_pkg::BYTE_W),
		.DEPTH (bscd_pkg::SCAN_BYTES)
	) u_scan_ram (
		.clk     (clk),
		.wr_en   (lookup),
		.wr_addr (addr_s1),
		.wr_data (cur_masked),
		.rd_en   (in_accept && in_range),
		.rd_addr (byte_index[bscd_pkg::ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	// entries never written read as all released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (lookup) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	// apply the keep mask to both bytes and find the changed bits
	assign prev        = valid_q[addr_s1] ? ram_rdata : '0;
	assign keep        = (index_s1 == masked_index_q) ? masked_keep_q : '1;
	assign cur_masked  = cur_s1 & keep;
	assign prev_masked = prev & keep;
	assign changes     = cur_masked ^ prev_masked;

	always_comb begin
		emit_load.load    = lookup && (changes != '0);
		emit_load.changes = changes;
		emit_load.states  = cur_masked;
		emit_load.index   = index_s1;
	end

	bscd_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (emit_load),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.button_number (button_number),
		.pressed       (pressed),
		.last_event    (last_event)
	);

endmodule
